// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

  // Number of line state entries. The line index is the low address bits,
  // so this must stay a power of two.
  localparam int LINE_COUNT = 1024;
  localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_I  = 4'd0,
    ST_S  = 4'd1,
    ST_E  = 4'd2,
    ST_O  = 4'd3,
    ST_M  = 4'd4,
    ST_F  = 4'd5,
    ST_IS = 4'd6,
    ST_IM = 4'd7,
    ST_SM = 4'd8,
    ST_OM = 4'd9,
    ST_FM = 4'd10
  } line_state_t;

  typedef enum logic [2:0] {
    RQ_LOAD  = 3'd0,
    RQ_STORE = 3'd1,
    RQ_GETS  = 3'd2,
    RQ_GETM  = 3'd3,
    RQ_DATA  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_GETS = 2'd1,
    CMD_GETM = 2'd2,
    CMD_DATA = 2'd3
  } bus_cmd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    line_state_t       state;
  } mem_wr_t;

  typedef struct packed {
    bus_cmd_t    cmd;
    logic        to_proc;
    logic        ash;
    logic        miss;
    logic        upg;
    logic        err;
    line_state_t nst;
  } xlate_res_t;

endpackage

// ===== rtl/core/msc_line_mem.sv =====
module msc_line_mem import msc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output line_state_t      rd_state,
  input  mem_wr_t          wr,
  output logic             clr_busy
);

  line_state_t      mem [LINE_COUNT];
  line_state_t      rd_state_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] clr_cnt_nxt;
  logic             clr_busy_nxt;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == IDX_W'(LINE_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // The clearing sweep owns the write port until every line reads as invalid.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= ST_I;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.state;
    end
    if (rd_en) begin
      rd_state_r <= mem[rd_idx];
    end
  end

  assign rd_state = rd_state_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/core/msc_xlate.sv =====
module msc_xlate import msc_pkg::*; (
  input  line_state_t st,
  input  logic [2:0]  req_type,
  input  logic        shared_seen,
  output xlate_res_t  res
);

  xlate_res_t raw;
  req_t       rq;
  logic       store;

  assign rq    = req_t'(req_type);
  assign store = (rq == RQ_STORE);

  always_comb begin
    raw         = '0;
    raw.cmd     = CMD_NONE;
    raw.nst     = st;
    unique case (rq)
      RQ_LOAD, RQ_STORE: begin
        unique case (st)
          ST_I: begin
            raw.cmd  = store ? CMD_GETM : CMD_GETS;
            raw.nst  = store ? ST_IM : ST_IS;
            raw.miss = 1'b1;
          end
          ST_S, ST_O, ST_F: begin
            if (store) begin
              raw.cmd  = CMD_GETM;
              raw.nst  = (st == ST_S) ? ST_SM : (st == ST_O) ? ST_OM : ST_FM;
              raw.miss = 1'b1;
            end else begin
              raw.to_proc = 1'b1;
            end
          end
          ST_E: begin
            raw.to_proc = 1'b1;
            if (store) begin
              raw.upg = 1'b1;
              raw.nst = ST_M;
            end
          end
          ST_M: raw.to_proc = 1'b1;
          default: raw.err = 1'b1;
        endcase
      end
      RQ_GETS, RQ_GETM, RQ_DATA: begin
        unique case (st)
          ST_I: ;
          ST_S: begin
            if (rq != RQ_DATA) begin
              raw.ash = 1'b1;
              if (rq == RQ_GETM) raw.nst = ST_I;
            end
          end
          ST_E, ST_O, ST_M, ST_F: begin
            if (rq == RQ_DATA) begin
              raw.err = 1'b1;
            end else begin
              raw.ash = 1'b1;
              raw.cmd = CMD_DATA;
              if (rq == RQ_GETM) raw.nst = ST_I;
              else raw.nst = (st == ST_E || st == ST_F) ? ST_F : ST_O;
            end
          end
          ST_IS: begin
            if (rq == RQ_DATA) begin
              raw.to_proc = 1'b1;
              raw.nst     = shared_seen ? ST_S : ST_E;
            end
          end
          ST_IM: begin
            if (rq == RQ_DATA) begin
              raw.to_proc = 1'b1;
              raw.nst     = ST_M;
            end
          end
          ST_SM: begin
            if (rq == RQ_DATA) begin
              raw.to_proc = 1'b1;
              raw.nst     = ST_M;
            end else begin
              raw.ash = 1'b1;
            end
          end
          ST_OM, ST_FM: begin
            if (rq == RQ_DATA) begin
              raw.to_proc = 1'b1;
              raw.nst     = ST_M;
            end else begin
              raw.ash = 1'b1;
              raw.cmd = CMD_DATA;
              if (rq == RQ_GETM) raw.nst = ST_IM;
            end
          end
          default: raw.err = 1'b1;
        endcase
      end
      default: raw.err = 1'b1;
    endcase
  end

  // An illegal message leaves the line alone and reports nothing else.
  always_comb begin
    res = raw;
    if (raw.err) begin
      res     = '0;
      res.cmd = CMD_NONE;
      res.err = 1'b1;
      res.nst = st;
    end
  end

endmodule

// ===== rtl/core/moesif_snoop_coherence_controller_top.sv =====
// An accepted item is registered with its line state read, then enters the output
// register when it is free. Throughput: one item per cycle while out_stall does not
// hold the output; the line state read-modify-write through one synchronous memory
// port pair sets that rate, with the last write forwarded. Reset: synchronous and
// active low; a clearing pass then sets all 1024 lines to I while in_stall is high.
module moesif_snoop_coherence_controller_top import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_block_addr,
  input  logic [3:0]  in_requester_id,
  input  logic        in_shared_seen,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_bus_cmd,
  output logic [31:0] out_bus_addr,
  output logic [3:0]  out_data_dest,
  output logic        out_data_to_proc,
  output logic        out_assert_shared,
  output logic        out_miss_flag,
  output logic        out_upgrade_flag,
  output logic        out_error_flag,
  output logic [3:0]  out_next_line_state
);

  logic        in_accept;
  logic        clr_busy;
  line_state_t rd_state;
  line_state_t cur_state;
  xlate_res_t  res;
  mem_wr_t     wr;
  mem_wr_t     lw_r;
  logic        s1_adv;

  logic             s1_valid_r;
  logic [2:0]       s1_req_r;
  logic [31:0]      s1_addr_r;
  logic [3:0]       s1_rid_r;
  logic             s1_shared_r;
  logic [IDX_W-1:0] s1_idx;

  logic        out_valid_r;
  logic [1:0]  out_cmd_r,  out_cmd_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [3:0]  out_dest_r, out_dest_nxt;
  logic        out_to_proc_r, out_ash_r, out_miss_r, out_upg_r, out_err_r;
  logic [3:0]  out_nst_r;

  assign in_accept = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clr_busy || (s1_valid_r && !s1_adv);
  assign s1_idx    = s1_addr_r[IDX_W-1:0];

  msc_line_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_idx   (in_block_addr[IDX_W-1:0]),
    .rd_state (rd_state),
    .wr       (wr),
    .clr_busy (clr_busy)
  );

  // The read for this item was issued while the previous item was still
  // writing, so the latest write to the same line wins over the memory data.
  assign cur_state = (lw_r.en && lw_r.idx == s1_idx) ? lw_r.state : rd_state;

  msc_xlate u_xlate (
    .st          (cur_state),
    .req_type    (s1_req_r),
    .shared_seen (s1_shared_r),
    .res         (res)
  );

  always_comb begin
    wr.en    = s1_adv && !res.err;
    wr.idx   = s1_idx;
    wr.state = res.nst;
  end

  always_comb begin
    out_cmd_nxt  = res.cmd;
    out_addr_nxt = (res.cmd != CMD_NONE || res.to_proc) ? s1_addr_r : '0;
    out_dest_nxt = (res.cmd == CMD_DATA) ? s1_rid_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lw_r.en     <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr.en) begin
        lw_r <= wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r    <= in_req_type;
      s1_addr_r   <= in_block_addr;
      s1_rid_r    <= in_requester_id;
      s1_shared_r <= in_shared_seen;
    end
    if (s1_adv) begin
      out_cmd_r     <= out_cmd_nxt;
      out_addr_r    <= out_addr_nxt;
      out_dest_r    <= out_dest_nxt;
      out_to_proc_r <= res.to_proc;
      out_ash_r     <= res.ash;
      out_miss_r    <= res.miss;
      out_upg_r     <= res.upg;
      out_err_r     <= res.err;
      out_nst_r     <= res.nst;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bus_cmd         = out_cmd_r;
  assign out_bus_addr        = out_addr_r;
  assign out_data_dest       = out_dest_r;
  assign out_data_to_proc    = out_to_proc_r;
  assign out_assert_shared   = out_ash_r;
  assign out_miss_flag       = out_miss_r;
  assign out_upgrade_flag    = out_upg_r;
  assign out_error_flag      = out_err_r;
  assign out_next_line_state = out_nst_r;

`ifndef SYNTH
  a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !s1_valid_r)
    else $error("item in flight during clearing pass");

  a_error_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_cmd_r == CMD_NONE && !out_to_proc_r && !out_ash_r))
    else $error("error result carries an action");

  a_dest_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dest_r != 4'd0) |-> (out_cmd_r == CMD_DATA))
    else $error("data destination without data supply");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("finished item did not reach the output register");
`endif

endmodule

// ===== verif/moesif_snoop_coherence_controller_top_tb.sv =====
`timescale 1ns / 1ps

module moesif_snoop_coherence_controller_top_tb;
  import msc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_LINES = 16;

  typedef struct packed {
    bus_cmd_t    cmd;
    logic [31:0] addr;
    logic [3:0]  dest;
    logic        to_proc;
    logic        ash;
    logic        miss;
    logic        upg;
    logic        err;
    line_state_t nst;
  } coh_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_block_addr = '0;
  logic [3:0]  in_requester_id = '0;
  logic        in_shared_seen = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_bus_cmd;
  logic [31:0] out_bus_addr;
  logic [3:0]  out_data_dest;
  logic        out_data_to_proc;
  logic        out_assert_shared;
  logic        out_miss_flag;
  logic        out_upgrade_flag;
  logic        out_error_flag;
  logic [3:0]  out_next_line_state;

  line_state_t line_states_shadow [LINE_COUNT];
  coh_result_t coherence_results_q [$];
  coh_result_t oldest_result;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  moesif_snoop_coherence_controller_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_block_addr       (in_block_addr),
    .in_requester_id     (in_requester_id),
    .in_shared_seen      (in_shared_seen),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bus_cmd         (out_bus_cmd),
    .out_bus_addr        (out_bus_addr),
    .out_data_dest       (out_data_dest),
    .out_data_to_proc    (out_data_to_proc),
    .out_assert_shared   (out_assert_shared),
    .out_miss_flag       (out_miss_flag),
    .out_upgrade_flag    (out_upgrade_flag),
    .out_error_flag      (out_error_flag),
    .out_next_line_state (out_next_line_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the line state copy and returns the result it causes.
  function automatic coh_result_t predict_coherence(logic [2:0] rq, logic [31:0] addr,
                                                    logic [3:0] rid, logic shared);
    int unsigned idx;
    line_state_t cur;
    coh_result_t r;
    logic        is_store;
    logic        is_data;
    logic        is_getm;
    idx = addr % LINE_COUNT;
    cur = line_states_shadow[idx];
    r = '0;
    r.nst = cur;
    is_store = (rq == RQ_STORE);
    is_data = (rq == RQ_DATA);
    is_getm = (rq == RQ_GETM);
    if (rq == RQ_LOAD || rq == RQ_STORE) begin
      case (cur)
        ST_I: begin
          r.cmd = is_store ? CMD_GETM : CMD_GETS;
          r.nst = is_store ? ST_IM : ST_IS;
          r.miss = 1'b1;
        end
        ST_S, ST_O, ST_F: begin
          if (is_store) begin
            r.cmd = CMD_GETM;
            r.nst = (cur == ST_S) ? ST_SM : ((cur == ST_O) ? ST_OM : ST_FM);
            r.miss = 1'b1;
          end else begin
            r.to_proc = 1'b1;
          end
        end
        ST_E: begin
          r.to_proc = 1'b1;
          if (is_store) begin
            r.upg = 1'b1;
            r.nst = ST_M;
          end
        end
        ST_M: r.to_proc = 1'b1;
        default: r.err = 1'b1;
      endcase
    end else if (rq <= RQ_DATA) begin
      case (cur)
        ST_I: ;
        ST_S: begin
          if (!is_data) begin
            r.ash = 1'b1;
            if (is_getm) r.nst = ST_I;
          end
        end
        ST_E, ST_O, ST_M, ST_F: begin
          if (is_data) begin
            r.err = 1'b1;
          end else begin
            r.ash = 1'b1;
            r.cmd = CMD_DATA;
            r.nst = is_getm ? ST_I : ((cur == ST_E || cur == ST_F) ? ST_F : ST_O);
          end
        end
        ST_IS: begin
          if (is_data) begin
            r.to_proc = 1'b1;
            r.nst = shared ? ST_S : ST_E;
          end
        end
        ST_IM, ST_SM, ST_OM, ST_FM: begin
          if (is_data) begin
            r.to_proc = 1'b1;
            r.nst = ST_M;
          end else if (cur != ST_IM) begin
            // SM only answers with shared; OM and FM also own the data.
            r.ash = 1'b1;
            if (cur != ST_SM) begin
              r.cmd = CMD_DATA;
              if (is_getm) r.nst = ST_IM;
            end
          end
        end
        default: r.err = 1'b1;
      endcase
    end else begin
      r.err = 1'b1;
    end

    if (r.err) begin
      r = '0;
      r.err = 1'b1;
      r.nst = cur;
    end else begin
      line_states_shadow[idx] = r.nst;
    end
    r.addr = (r.cmd != CMD_NONE || r.to_proc) ? addr : '0;
    r.dest = (r.cmd == CMD_DATA) ? rid : '0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (coherence_results_q.size() == 0) begin
        $error("result item arrived with no request pending");
        mismatch_count++;
      end else begin
        oldest_result = coherence_results_q.pop_front();
        check_field("bus_cmd", oldest_result.cmd, out_bus_cmd);
        check_field("bus_addr", oldest_result.addr, out_bus_addr);
        check_field("data_dest", oldest_result.dest, out_data_dest);
        check_field("data_to_proc", oldest_result.to_proc, out_data_to_proc);
        check_field("assert_shared", oldest_result.ash, out_assert_shared);
        check_field("miss_flag", oldest_result.miss, out_miss_flag);
        check_field("upgrade_flag", oldest_result.upg, out_upgrade_flag);
        check_field("error_flag", oldest_result.err, out_error_flag);
        check_field("next_line_state", oldest_result.nst, out_next_line_state);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("moesif_snoop_coherence_controller_top verification failed");
      $finish;
    end
  end

  // Presents one item, holds it until accepted and records its result.
  task automatic send_item(logic [2:0] rq, logic [31:0] addr, logic [3:0] rid,
                           logic shared);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= rq;
    in_block_addr   <= addr;
    in_requester_id <= rid;
    in_shared_seen  <= shared;
    do @(posedge clk); while (in_stall);
    coherence_results_q.push_back(predict_coherence(rq, addr, rid, shared));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coherence_results_q.size() != 0) @(posedge clk);
  endtask

  // Walks three lines through the stable and transient states.
  task automatic test_state_walks();
    send_idle_pct = 25;
    recv_idle_pct = 58;
    send_item(RQ_LOAD, 32'hFFFF_FFFF, 4'h0, 1'b0);
    send_item(RQ_DATA, 32'hFFFF_FFFF, 4'h3, 1'b0);
    send_item(RQ_STORE, 32'hFFFF_FFFF, 4'h0, 1'b1);
    send_item(RQ_GETS, 32'hFFFF_FFFF, 4'hF, 1'b1);
    send_item(RQ_STORE, 32'hFFFF_FFFF, 4'h0, 1'b0);
    send_item(RQ_GETM, 32'hFFFF_FFFF, 4'h0, 1'b0);
    send_item(RQ_DATA, 32'hFFFF_FFFF, 4'h9, 1'b1);
    send_item(RQ_GETM, 32'hFFFF_FFFF, 4'hF, 1'b0);
    send_item(RQ_GETS, 32'hFFFF_FFFF, 4'h5, 1'b0);
    send_item(RQ_LOAD, 32'h0000_0000, 4'h0, 1'b0);
    send_item(RQ_DATA, 32'h0000_0000, 4'h0, 1'b1);
    send_item(RQ_DATA, 32'h0000_0000, 4'h0, 1'b1);
    send_item(RQ_STORE, 32'h0000_0000, 4'h0, 1'b0);
    send_item(RQ_GETS, 32'h0000_0000, 4'hA, 1'b0);
    send_item(RQ_DATA, 32'h0000_0000, 4'h0, 1'b0);
    send_item(RQ_LOAD, 32'h8000_0001, 4'h0, 1'b0);
    send_item(RQ_DATA, 32'h8000_0001, 4'h0, 1'b0);
    send_item(RQ_GETS, 32'h8000_0001, 4'h6, 1'b0);
    send_item(RQ_STORE, 32'h8000_0001, 4'h0, 1'b0);
    send_item(RQ_GETS, 32'h8000_0001, 4'hC, 1'b1);
    send_item(RQ_GETM, 32'h8000_0001, 4'h1, 1'b1);
  endtask

  // Requests that are illegal in the state they hit must leave it untouched.
  task automatic test_illegal_messages();
    send_item(RQ_STORE, 32'h8000_0001, 4'h0, 1'b0);
    send_item(3'd5, 32'h8000_0001, 4'hF, 1'b1);
    send_item(RQ_DATA, 32'h8000_0001, 4'h0, 1'b0);
    send_item(RQ_DATA, 32'h8000_0001, 4'h0, 1'b0);
    send_item(3'd6, 32'h0000_0000, 4'h0, 1'b0);
    send_item(3'd7, 32'hFFFF_FFFF, 4'hF, 1'b1);
  endtask

  // Mostly hammers a few lines so that their states evolve; lines waiting
  // for data usually get it, and a slice of the traffic is illegal.
  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    int unsigned idx;
    int          roll;
    logic [31:0] addr;
    logic [2:0]  rq;
    line_state_t cur;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 8) idx = $urandom_range(HOT_LINES - 1);
      else idx = $urandom_range(LINE_COUNT - 1);
      addr = $urandom;
      addr[IDX_W-1:0] = idx[IDX_W-1:0];
      cur = line_states_shadow[idx];
      roll = $urandom_range(99);
      if (roll < 3) rq = 3'($urandom_range(7, 5));
      else if (cur >= ST_IS && roll < 60) rq = RQ_DATA;
      else if (roll < 10) rq = RQ_DATA;
      else rq = 3'($urandom_range(3));
      send_item(rq, addr, 4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    foreach (line_states_shadow[i]) line_states_shadow[i] = ST_I;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_state_walks();
    test_illegal_messages();
    test_random_traffic(540, 25, 58);
    wait_for_drain();
    test_random_traffic(540, 58, 25);
    wait_for_drain();
    test_random_traffic(540, 0, 0);
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && coherence_results_q.size() == 0) begin
      $display("moesif_snoop_coherence_controller_top verification clean");
    end else begin
      $display("moesif_snoop_coherence_controller_top verification failed");
    end
    $finish;
  end

endmodule
